@@ rtl/core/cfpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfpc_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the framed
// packet checker.
// ----------------------------------------------------------------------------
package cfpc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [8:0] HEAD_LEN = 9'd8;
  localparam logic [9:0] MIN_LEN  = 10'd10;
  localparam logic [8:0] POS_MAX  = 9'd511;
  localparam logic [7:0] START_RESET = 8'hAA;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_LEN_ERR   = 3'd3;
  localparam logic [2:0] ST_CRC_ERR   = 3'd4;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_value;
    logic [7:0]  payload_position;
    logic [7:0]  frame_version;
    logic [7:0]  message_kind;
    logic [7:0]  source_node;
    logic [7:0]  dest_node;
    logic [15:0] sequence_number;
    logic [7:0]  payload_count;
    logic [15:0] crc_seen;
    logic [15:0] crc_worked;
    logic [2:0]  frame_status;
  } result_t;

  // MSB-first CRC update by one byte, unrolled over eight bits
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/crc_framed_packet_checker_top.sv @@
// ----------------------------------------------------------------------------
// crc_framed_packet_checker_top
// Byte-wide deframer: 8-byte header, payload, big-endian CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one raw frame byte per item
//   with final_byte_i marking the last byte of the frame.
//   Output channel (out_valid_o / out_ready_i) carries results: a payload item
//   (kind 0) for every payload byte of a frame whose start byte matched, and
//   one status item (kind 1) on the final byte; header, CRC only on OK/CRC_ERR.
//   Bytes that give no result (header, CRC, excess bytes) are simply consumed.
// Timing:
//   One byte per cycle sustained while in_ready_o is high. A result is registered
//   in the output buffer when its byte is accepted. The CRC advances by one unrolled
//   byte step per item, two bytes behind the input so the trailing CRC is excluded.
// Stall:
//   An output register plus one skid entry decouple the sides; in_ready_o
//   drops only when both hold an item, so bytes keep flowing while one
//   result waits.
// Reset:
//   Frame state returns to frame start, CRC to 0xFFFF, start byte to 0xAA.
//   cfg_we_i loads the expected start byte; write it only while idle.
// ----------------------------------------------------------------------------
module crc_framed_packet_checker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        final_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_value_o,
  output logic [7:0]  payload_position_o,
  output logic [7:0]  frame_version_o,
  output logic [7:0]  message_kind_o,
  output logic [7:0]  source_node_o,
  output logic [7:0]  dest_node_o,
  output logic [15:0] sequence_number_o,
  output logic [7:0]  payload_count_o,
  output logic [15:0] crc_seen_o,
  output logic [15:0] crc_worked_o,
  output logic [2:0]  frame_status_o
);

  logic [7:0]        start_byte_q;
  logic              accept;
  logic              res_valid;
  cfpc_pkg::result_t res;
  cfpc_pkg::result_t out_res;

  // expected start byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= cfpc_pkg::START_RESET;
    end else if (cfg_we_i) begin
      start_byte_q <= cfg_wdata_i;
    end
  end

  assign accept = in_valid_i & in_ready_o;

  // frame tracking and result formation, all in the accept cycle
  cfpc_frame_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .final_byte_i (final_byte_i),
    .start_byte_i (start_byte_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result register with skid entry
  cfpc_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept & res_valid),
    .in_data_i   (res),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .out_ready_i (out_ready_i)
  );

  assign result_kind_o      = out_res.result_kind;
  assign payload_value_o    = out_res.payload_value;
  assign payload_position_o = out_res.payload_position;
  assign frame_version_o    = out_res.frame_version;
  assign message_kind_o     = out_res.message_kind;
  assign source_node_o      = out_res.source_node;
  assign dest_node_o        = out_res.dest_node;
  assign sequence_number_o  = out_res.sequence_number;
  assign payload_count_o    = out_res.payload_count;
  assign crc_seen_o         = out_res.crc_seen;
  assign crc_worked_o       = out_res.crc_worked;
  assign frame_status_o     = out_res.frame_status;

endmodule

@@ rtl/core/cfpc_frame_core.sv @@
// ----------------------------------------------------------------------------
// cfpc_frame_core
// Per-frame state (position, CRC, header, delay bytes) and the combinational
// result logic for each accepted byte.
// ----------------------------------------------------------------------------
module cfpc_frame_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              final_byte_i,
  input  logic [7:0]        start_byte_i,
  output logic              res_valid_o,
  output cfpc_pkg::result_t res_o
);

  logic [8:0]  pos_q;
  logic [15:0] crc_q;
  logic [7:0]  dly0_q, dly1_q;
  logic        matched_q;
  logic [7:0]  hdr_q [7];

  logic [15:0] crc_cur;
  logic [9:0]  len;
  logic [15:0] seen;
  logic        matched;
  logic [2:0]  status;
  logic [8:0]  pay_idx;
  logic        pay_emit;

  always_comb begin
    crc_cur  = (pos_q >= 9'd2) ? cfpc_pkg::crc_feed(crc_q, dly0_q) : crc_q;
    len      = {1'b0, pos_q} + 10'd1;
    seen     = {dly1_q, rx_byte_i};
    matched  = (pos_q == 9'd0) ? (rx_byte_i == start_byte_i) : matched_q;
    pay_idx  = pos_q - cfpc_pkg::HEAD_LEN;
    pay_emit = (pos_q >= cfpc_pkg::HEAD_LEN) && matched_q && (pay_idx < {1'b0, hdr_q[6]});

    if (len < cfpc_pkg::MIN_LEN) begin
      status = cfpc_pkg::ST_SHORT;
    end else if (!matched) begin
      status = cfpc_pkg::ST_BAD_START;
    end else if (len != cfpc_pkg::MIN_LEN + {2'b00, hdr_q[6]}) begin
      status = cfpc_pkg::ST_LEN_ERR;
    end else if (seen != crc_cur) begin
      status = cfpc_pkg::ST_CRC_ERR;
    end else begin
      status = cfpc_pkg::ST_OK;
    end

    res_o = '0;
    if (final_byte_i) begin
      res_valid_o        = 1'b1;
      res_o.result_kind  = cfpc_pkg::KIND_STATUS;
      res_o.frame_status = status;
      if (status == cfpc_pkg::ST_OK || status == cfpc_pkg::ST_CRC_ERR) begin
        res_o.frame_version   = hdr_q[0];
        res_o.message_kind    = hdr_q[1];
        res_o.source_node     = hdr_q[2];
        res_o.dest_node       = hdr_q[3];
        res_o.sequence_number = {hdr_q[4], hdr_q[5]};
        res_o.payload_count   = hdr_q[6];
        res_o.crc_seen        = seen;
        res_o.crc_worked      = crc_cur;
      end
    end else begin
      res_valid_o            = pay_emit;
      res_o.result_kind      = cfpc_pkg::KIND_PAYLOAD;
      res_o.payload_value    = rx_byte_i;
      res_o.payload_position = pay_idx[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      crc_q     <= cfpc_pkg::CRC_INIT;
      dly0_q    <= '0;
      dly1_q    <= '0;
      matched_q <= 1'b0;
      for (int i = 0; i < 7; i++) begin
        hdr_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (final_byte_i) begin
        // back to frame start
        pos_q     <= '0;
        crc_q     <= cfpc_pkg::CRC_INIT;
        dly0_q    <= '0;
        dly1_q    <= '0;
        matched_q <= 1'b0;
        for (int i = 0; i < 7; i++) begin
          hdr_q[i] <= '0;
        end
      end else begin
        crc_q  <= crc_cur;
        dly0_q <= dly1_q;
        dly1_q <= rx_byte_i;
        if (pos_q == 9'd0) begin
          matched_q <= (rx_byte_i == start_byte_i);
        end
        for (int i = 0; i < 7; i++) begin
          if (pos_q == 9'(i + 1)) begin
            hdr_q[i] <= rx_byte_i;
          end
        end
        if (pos_q < cfpc_pkg::POS_MAX) begin
          pos_q <= pos_q + 9'd1;
        end
      end
    end
  end

endmodule

@@ rtl/core/cfpc_out_buf.sv @@
// ----------------------------------------------------------------------------
// cfpc_out_buf
// Output register with one skid entry; ready to the source is registered.
// ----------------------------------------------------------------------------
module cfpc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  cfpc_pkg::result_t in_data_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output cfpc_pkg::result_t out_data_o,
  input  logic              out_ready_i
);

  logic              out_v_q, skid_v_q;
  cfpc_pkg::result_t out_q, skid_q;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_valid_i;
      end
    end else if (in_valid_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : in_data_i;
    end else if (in_valid_i && !skid_v_q) begin
      skid_q <= in_data_i;
    end
  end

endmodule
